// File: design/smu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and constants of the stream mean unit.
// ----------------------------------------------------------------------------
package smu_pkg;

    // default sizes
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // mean_mode register codes
    localparam logic [1:0] MODE_ARITH = 2'd0;
    localparam logic [1:0] MODE_GEO   = 2'd1;
    localparam logic [1:0] MODE_HARM  = 2'd2;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // per-sample operation chosen by the front end
    typedef enum logic [1:0] {
        OP_ADD,
        OP_LOG,
        OP_RECIP,
        OP_ZERO
    } t_op;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG,
        ST_LOGACC,
        ST_DIV,
        ST_DIVEND,
        ST_COUNT,
        ST_FINAL,
        ST_EXP,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] sample;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] mean_value;
        logic [15:0] sample_total;
        logic        bad_sample;
    } t_out_item;

    // classified beat between front and back
    typedef struct packed {
        logic [1:0]  mode;
        t_op         op;
        logic [31:0] sample;
        logic        last;
    } t_work;

endpackage

// File: design/smu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_front
// Input side: classifies each accepted sample and holds it in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module smu_front import smu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mode,
    input  logic       push,
    input  t_in_item   i_in_item,
    output logic       full,
    output logic       o_work_valid,
    output t_work      o_work,
    input  logic       i_work_ready
);

    t_work      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_work      w_new;

    assign full         = (r_cnt == 2'd2);
    assign o_work_valid = (r_cnt != 2'd0);
    assign o_work       = r_q[r_rp];
    assign w_push       = push && !full;
    assign w_pop        = o_work_valid && i_work_ready;

    // classify the beat by mode and sample value
    always_comb begin
        w_new.mode   = i_mode;
        w_new.sample = i_in_item.sample;
        w_new.last   = i_in_item.is_last;
        if (i_mode == MODE_GEO || i_mode == MODE_HARM) begin
            if (i_in_item.sample == 32'd0) begin
                w_new.op = OP_ZERO;
            end else if (i_mode == MODE_GEO) begin
                w_new.op = OP_LOG;
            end else begin
                w_new.op = OP_RECIP;
            end
        end else begin
            w_new.op = OP_ADD;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_new;
    end

endmodule

// File: design/smu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_back
// Sequencer that accumulates samples (add, log2, reciprocal) and forms the
// mean with a shared restoring divider, a square loop and an exp2 loop.
// ----------------------------------------------------------------------------
module smu_back import smu_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_work_valid,
    input  t_work     i_work,
    output logic      o_work_ready,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_res_ready
);

    localparam int DIV_W = (COUNT_BITS + 2 * FRAC_BITS > 64) ?
                           (COUNT_BITS + 2 * FRAC_BITS) : 64;
    localparam int IW    = $clog2(DIV_W + 1);
    localparam int CIW   = $clog2(FRAC_BITS);

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n, r, b;
        n = n_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // k-th successive root of 2.0 in Q.30
    function automatic logic [31:0] root_step(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 0; j < k; j++) c = isqrt64(c << 30);
        return c[31:0];
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // root constants for the exp2 loop
    logic [31:0] c_tab [FRAC_BITS];
    for (genvar gi = 0; gi < FRAC_BITS; gi++) begin : g_root
        localparam logic [31:0] CV = root_step(gi + 1);
        assign c_tab[gi] = CV;
    end

    t_state                r_state, n_state;
    logic [63:0]           r_sum, n_sum;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_zero, n_zero;
    t_work                 r_item, n_item;
    logic [31:0]           r_m, n_m;
    logic [4:0]            r_p, n_p;
    logic [FRAC_BITS-1:0]  r_frac, n_frac;
    logic [IW-1:0]         r_iter, n_iter;
    logic [DIV_W-1:0]      r_dvd, n_dvd;
    logic [63:0]           r_dsr, n_dsr;
    logic [63:0]           r_rem, n_rem;
    logic [63:0]           r_quo, n_quo;
    logic                  r_ovf, n_ovf;
    logic                  r_final, n_final;
    logic                  r_neg, n_neg;
    logic [31:0]           r_v, n_v;
    logic [63:0]           r_ip, n_ip;
    logic [31:0]           r_mean, n_mean;

    logic [4:0]  w_lead;
    logic [63:0] w_sq;
    logic [32:0] w_sqs;
    logic [63:0] w_prod;
    logic [64:0] w_t, w_diff;
    logic        w_ge;
    logic [63:0] w_logv, w_qs, w_s, w_nsh, w_wide, w_mag;

    // top set bit of the incoming sample
    always_comb begin
        w_lead = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (i_work.sample[k]) w_lead = 5'(k);
        end
    end

    // datapath terms
    assign w_sq   = 64'(r_m) * 64'(r_m);
    assign w_sqs  = w_sq[63:31];
    assign w_prod = 64'(r_v) * 64'(c_tab[r_iter[CIW-1:0]]);
    assign w_t    = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_dsr});
    assign w_diff = w_t - {1'b0, r_dsr};
    assign w_logv = (($signed(64'(r_p)) - 64'(FRAC_BITS)) <<< FRAC_BITS) | 64'(r_frac);
    assign w_qs   = r_neg ? (64'd0 - r_quo) : r_quo;
    assign w_s    = r_ip + 64'(FRAC_BITS) - 64'd30;
    assign w_nsh  = 64'd0 - w_s;
    assign w_wide = 64'(r_v) << w_s[4:0];
    assign w_mag  = r_sum[63] ? (64'd0 - r_sum) : r_sum;

    assign o_work_ready       = (r_state == ST_IDLE);
    assign o_res_valid        = (r_state == ST_DONE);
    assign o_res.mean_value   = r_mean;
    assign o_res.sample_total = 16'(r_count);
    assign o_res.bad_sample   = r_zero;

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_count = r_count;
        n_zero  = r_zero;
        n_item  = r_item;
        n_m     = r_m;
        n_p     = r_p;
        n_frac  = r_frac;
        n_iter  = r_iter;
        n_dvd   = r_dvd;
        n_dsr   = r_dsr;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_ovf   = r_ovf;
        n_final = r_final;
        n_neg   = r_neg;
        n_v     = r_v;
        n_ip    = r_ip;
        n_mean  = r_mean;
        unique case (r_state)
            ST_IDLE: begin
                if (i_work_valid) begin
                    n_item = i_work;
                    case (i_work.op)
                        OP_ZERO: begin
                            n_zero  = 1'b1;
                            n_state = ST_COUNT;
                        end
                        OP_ADD: begin
                            n_sum   = sat_add(r_sum, 64'(i_work.sample));
                            n_state = ST_COUNT;
                        end
                        OP_LOG: begin
                            n_m     = i_work.sample << (5'd31 - w_lead);
                            n_p     = w_lead;
                            n_frac  = '0;
                            n_iter  = '0;
                            n_state = ST_LOG;
                        end
                        default: begin
                            // reciprocal 2^(2F) / sample
                            n_dvd   = DIV_W'(1) << (DIV_W - 1);
                            n_dsr   = 64'(i_work.sample);
                            n_rem   = '0;
                            n_quo   = '0;
                            n_ovf   = 1'b0;
                            n_iter  = IW'(2 * FRAC_BITS + 1);
                            n_final = 1'b0;
                            n_state = ST_DIV;
                        end
                    endcase
                end
            end
            ST_LOG: begin
                // one square per cycle, one fraction bit out
                n_frac = {r_frac[FRAC_BITS-2:0], w_sqs[32]};
                n_m    = w_sqs[32] ? w_sqs[32:1] : w_sqs[31:0];
                n_iter = r_iter + 1'b1;
                if (r_iter == IW'(FRAC_BITS - 1)) n_state = ST_LOGACC;
            end
            ST_LOGACC: begin
                n_sum   = r_sum + w_logv;
                n_state = ST_COUNT;
            end
            ST_DIV: begin
                // restoring divide step
                n_dvd  = r_dvd << 1;
                n_rem  = w_ge ? w_diff[63:0] : w_t[63:0];
                n_quo  = {r_quo[62:0], w_ge};
                n_ovf  = r_ovf | r_quo[63];
                n_iter = r_iter - 1'b1;
                if (r_iter == IW'(1)) n_state = ST_DIVEND;
            end
            ST_DIVEND: begin
                if (!r_final) begin
                    n_sum   = sat_add(r_sum, r_quo);
                    n_state = ST_COUNT;
                end else if (r_item.mode == MODE_GEO) begin
                    n_ip    = 64'($signed(w_qs) >>> FRAC_BITS);
                    n_frac  = w_qs[FRAC_BITS-1:0];
                    n_v     = 32'd1 << 30;
                    n_iter  = '0;
                    n_state = ST_EXP;
                end else begin
                    n_mean  = (r_ovf || r_quo[63:32] != 32'd0) ? MAX32 : r_quo[31:0];
                    n_state = ST_DONE;
                end
            end
            ST_COUNT: begin
                if (r_count != '1) n_count = r_count + 1'b1;
                n_state = r_item.last ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL: begin
                n_rem   = '0;
                n_quo   = '0;
                n_ovf   = 1'b0;
                n_final = 1'b1;
                if ((r_item.mode == MODE_GEO || r_item.mode == MODE_HARM) && r_zero) begin
                    n_mean  = '0;
                    n_state = ST_DONE;
                end else if (r_item.mode == MODE_GEO) begin
                    n_neg   = r_sum[63];
                    n_dvd   = DIV_W'(w_mag) << (DIV_W - 64);
                    n_dsr   = 64'(r_count);
                    n_iter  = IW'(64);
                    n_state = ST_DIV;
                end else if (r_item.mode == MODE_HARM) begin
                    if (r_sum == 64'd0) begin
                        n_mean  = MAX32;
                        n_state = ST_DONE;
                    end else begin
                        n_dvd   = DIV_W'(r_count) << (DIV_W - COUNT_BITS);
                        n_dsr   = r_sum;
                        n_iter  = IW'(COUNT_BITS + 2 * FRAC_BITS);
                        n_state = ST_DIV;
                    end
                end else begin
                    n_dvd   = DIV_W'(r_sum) << (DIV_W - 64);
                    n_dsr   = 64'(r_count);
                    n_iter  = IW'(64);
                    n_state = ST_DIV;
                end
            end
            ST_EXP: begin
                // multiply in one root per set fraction bit
                if (r_frac[FRAC_BITS-1]) n_v = w_prod[61:30];
                n_frac = r_frac << 1;
                n_iter = r_iter + 1'b1;
                if (r_iter == IW'(FRAC_BITS - 1)) n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (w_s[63]) begin
                    n_mean = (w_nsh >= 64'd64) ? 32'd0 : 32'(r_v >> w_nsh[5:0]);
                end else if ($signed(w_s) >= 64'sd32) begin
                    n_mean = MAX32;
                end else begin
                    n_mean = (w_wide[63:32] != 32'd0) ? MAX32 : w_wide[31:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_sum   = '0;
                    n_count = '0;
                    n_zero  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_count <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_zero  <= n_zero;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_m     <= n_m;
        r_p     <= n_p;
        r_frac  <= n_frac;
        r_iter  <= n_iter;
        r_dvd   <= n_dvd;
        r_dsr   <= n_dsr;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_ovf   <= n_ovf;
        r_final <= n_final;
        r_neg   <= n_neg;
        r_v     <= n_v;
        r_ip    <= n_ip;
        r_mean  <= n_mean;
    end

    // a set never ends with an empty count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL) |-> (r_count != '0))
        else $error("final step with zero count");

    // a delivered result clears the set state
    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> (r_sum == 64'd0 && r_count == '0 && !r_zero))
        else $error("state not cleared after result");

    // a taken beat always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_work_ready && i_work_valid) |=> (r_state != ST_IDLE))
        else $error("beat taken but sequencer stayed idle");

    // divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dsr != 64'd0))
        else $error("divide by zero");

endmodule

// File: design/stream_mean_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_mean_unit_top
// Arithmetic, geometric or harmonic mean over sets of Q16.16 samples.
// ----------------------------------------------------------------------------
// Samples enter through a two-entry queue and are worked off one at a time by
// a sequencer. Per sample, a geometric sample takes one squaring per log2
// fraction bit and a harmonic sample a bit-serial reciprocal divide. The
// sample marked last adds the result step: a 64-step divide for arithmetic, a
// 64-step divide plus one exp2 multiply per fraction bit for geometric, and a
// divide of the count by the sum for harmonic, all on the shared restoring
// divider. The result waits in an output register while new samples are
// taken in. The user must write mean_mode through the cfg channel only
// between sets; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stream_mean_unit_top import smu_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  t_in_item   i_in_item,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic      r_mode;
    logic [1:0] r_mode_q;
    logic      w_work_valid, w_work_ready;
    t_work     w_work;
    logic      w_res_valid, w_res_ready;
    t_out_item w_res;
    logic      r_out_valid;
    t_out_item r_out_item;

    // mode register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_q <= MODE_ARITH;
            r_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode_q <= i_cfg_data;
            r_mode   <= 1'b1;
        end
    end

    smu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode_q),
        .push         (push),
        .i_in_item    (i_in_item),
        .full         (full),
        .o_work_valid (w_work_valid),
        .o_work       (w_work),
        .i_work_ready (w_work_ready)
    );

    smu_back #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_ready (w_work_ready),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    // output register
    assign w_res_ready = !r_out_valid || pop;
    assign empty       = !r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) r_out_item <= w_res;
    end

    // a result is never overwritten before it is popped
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_out_item)))
        else $error("pending result lost");

    // mode tracks the last config write
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && r_mode) |=> (r_mode_q == $past(i_cfg_data)))
        else $error("mode write lost");

endmodule
